### src/nnir_pkg.sv
// ----------------------------------------------------------------------------
// nnir_pkg
// Shared types and constants for the nearest-neighbour image rotator.
// ----------------------------------------------------------------------------
package nnir_pkg;

   localparam int COORD_W   = 7;   // col / row field width
   localparam int PIXEL_W   = 8;
   localparam int CHAN_W    = 2;
   localparam int DIM_W     = 8;   // image_width / image_height registers
   localparam int TRIG_W    = 16;  // Q1.14 cosine and sine
   localparam int DELTA_W   = 10;  // 2x - w, signed
   localparam int PROD_W    = DELTA_W + TRIG_W;
   localparam int FRAC_BITS = 15;  // sums are in units of 2^-15
   localparam int HALF_BITS = 14;  // w*2^14 term
   localparam int SUM_W     = 28;
   localparam int POS_W     = SUM_W - FRAC_BITS;
   localparam int CSR_IDX_W = 2;

   // csr register indexes
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COS_Q14      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SIN_Q14      = 2'd3;

   // action codes
   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_READ  = 1'b1;

   // reset values of the csr registers
   localparam logic [DIM_W-1:0]         RESET_WIDTH  = 8'd128;
   localparam logic [DIM_W-1:0]         RESET_HEIGHT = 8'd128;
   localparam logic signed [TRIG_W-1:0] RESET_COS    = 16'sd16384;
   localparam logic signed [TRIG_W-1:0] RESET_SIN    = 16'sd0;

   typedef struct packed {
      logic               action;
      logic [CHAN_W-1:0]  channel;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [PIXEL_W-1:0] pixel_in;
   } item_type;

   // stage load enables of the coordinate pipeline
   typedef struct packed {
      logic prod;
      logic sum;
   } advance_type;

endpackage

### src/nnir_map.sv
// ----------------------------------------------------------------------------
// nnir_map
// Two-stage inverse mapping: four products, then the two position sums.
// ----------------------------------------------------------------------------
module nnir_map (
   input  logic                                   clock,
   input  nnir_pkg::advance_type                  advance,
   input  logic [nnir_pkg::COORD_W-1:0]           col,
   input  logic [nnir_pkg::COORD_W-1:0]           row,
   input  logic [nnir_pkg::DIM_W-1:0]             width,
   input  logic [nnir_pkg::DIM_W-1:0]             height,
   input  logic signed [nnir_pkg::TRIG_W-1:0]     cos_q14,
   input  logic signed [nnir_pkg::TRIG_W-1:0]     sin_q14,
   output logic signed [nnir_pkg::SUM_W-1:0]      nx,
   output logic signed [nnir_pkg::SUM_W-1:0]      ny
);

   localparam int PAD_W = nnir_pkg::SUM_W - nnir_pkg::DIM_W - nnir_pkg::HALF_BITS;
   localparam int EXT_W = nnir_pkg::SUM_W - nnir_pkg::PROD_W;

   logic signed [nnir_pkg::DELTA_W-1:0] dx2;
   logic signed [nnir_pkg::DELTA_W-1:0] dy2;
   logic signed [nnir_pkg::PROD_W-1:0]  xc_ff, ys_ff, xs_ff, yc_ff;
   logic signed [nnir_pkg::SUM_W-1:0]   xc_ext, ys_ext, xs_ext, yc_ext;
   logic signed [nnir_pkg::SUM_W-1:0]   w_half, h_half, half;
   logic signed [nnir_pkg::SUM_W-1:0]   nx_in, ny_in;
   logic signed [nnir_pkg::SUM_W-1:0]   nx_ff, ny_ff;

   // doubled offsets from the centre
   assign dx2 = $signed({2'b00, col, 1'b0}) - $signed({2'b00, width});
   assign dy2 = $signed({2'b00, row, 1'b0}) - $signed({2'b00, height});

   always_ff @(posedge clock) begin
      if (advance.prod) begin
         xc_ff <= dx2 * cos_q14;
         ys_ff <= dy2 * sin_q14;
         xs_ff <= dx2 * sin_q14;
         yc_ff <= dy2 * cos_q14;
      end
   end

   assign xc_ext = {{EXT_W{xc_ff[nnir_pkg::PROD_W-1]}}, xc_ff};
   assign ys_ext = {{EXT_W{ys_ff[nnir_pkg::PROD_W-1]}}, ys_ff};
   assign xs_ext = {{EXT_W{xs_ff[nnir_pkg::PROD_W-1]}}, xs_ff};
   assign yc_ext = {{EXT_W{yc_ff[nnir_pkg::PROD_W-1]}}, yc_ff};
   assign w_half = $signed({{PAD_W{1'b0}}, width, {nnir_pkg::HALF_BITS{1'b0}}});
   assign h_half = $signed({{PAD_W{1'b0}}, height, {nnir_pkg::HALF_BITS{1'b0}}});
   assign half   = $signed(nnir_pkg::SUM_W'(1) <<< nnir_pkg::HALF_BITS);

   assign nx_in = w_half + xc_ext + ys_ext + half;
   assign ny_in = h_half - xs_ext + yc_ext + half;

   always_ff @(posedge clock) begin
      if (advance.sum) begin
         nx_ff <= nx_in;
         ny_ff <= ny_in;
      end
   end

   assign nx = nx_ff;
   assign ny = ny_ff;

endmodule

### src/nearest_neighbor_image_rotate.sv
// A read transfer passes stages s1 to s3 and gives its result from the s4 register.
// Throughput: one item per cycle while rsp_stall is low; the image store takes at most one access per cycle.
// Writes pass the same pipeline and touch the store in order with reads.
// Reset clears the pipeline valid flags and the csr registers; the image
// store is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
// nearest_neighbor_image_rotate
// Nearest-neighbour rotation about the image centre with crop and zero fill.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_rotate #(
   parameter int MAX_WIDTH    = 128,
   parameter int MAX_HEIGHT   = 128,
   parameter int MAX_CHANNELS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_write_en,
   input  logic [nnir_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [nnir_pkg::TRIG_W-1:0]         csr_write_data,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic [nnir_pkg::CHAN_W-1:0]         req_channel,
   input  logic [nnir_pkg::COORD_W-1:0]        req_col,
   input  logic [nnir_pkg::COORD_W-1:0]        req_row,
   input  logic [nnir_pkg::PIXEL_W-1:0]        req_pixel_in,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [nnir_pkg::PIXEL_W-1:0]        rsp_pixel_out,
   output logic                                rsp_outside
);

   localparam int DEPTH      = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
   localparam int PLANE_SIZE = MAX_HEIGHT * MAX_WIDTH;
   localparam int AW         = $clog2(DEPTH);
   localparam int WCAP       = (MAX_WIDTH > 255) ? 255 : MAX_WIDTH;
   localparam int HCAP       = (MAX_HEIGHT > 255) ? 255 : MAX_HEIGHT;
   localparam int POS_PAD    = nnir_pkg::POS_W - nnir_pkg::DIM_W;
   localparam int FB         = nnir_pkg::FRAC_BITS;
   localparam int SW         = nnir_pkg::SUM_W;

   // csr registers
   logic [nnir_pkg::DIM_W-1:0]         width_ff, height_ff;
   logic signed [nnir_pkg::TRIG_W-1:0] cos_ff, sin_ff;
   logic [nnir_pkg::DIM_W-1:0]         w_eff, h_eff;

   // pipeline
   nnir_pkg::item_type  s1_item_ff, s2_item_ff, s3_item_ff;
   logic                s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic                s1_valid_in, s2_valid_in, s3_valid_in, s4_valid_in;
   logic                s1_free, s2_free, s3_free, s4_free;
   logic                move1, move2, move3;
   nnir_pkg::advance_type advance;

   logic signed [SW-1:0]              nx, ny;
   logic [nnir_pkg::POS_W-1:0]        sx, sy;
   logic                              x_below, y_below, x_off, y_off, ch_off;
   logic                              outside_in, outside_ff;
   logic                              wr_ok;
   logic [AW-1:0]                     rd_addr, wr_addr;
   logic [nnir_pkg::PIXEL_W-1:0]      rd_data_ff;
   logic [nnir_pkg::PIXEL_W-1:0]      image_mem [DEPTH];

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= nnir_pkg::RESET_WIDTH;
         height_ff <= nnir_pkg::RESET_HEIGHT;
         cos_ff    <= nnir_pkg::RESET_COS;
         sin_ff    <= nnir_pkg::RESET_SIN;
      end else if (csr_write_en) begin
         unique case (csr_index)
            nnir_pkg::REG_IMAGE_WIDTH:  width_ff  <= csr_write_data[nnir_pkg::DIM_W-1:0];
            nnir_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_write_data[nnir_pkg::DIM_W-1:0];
            nnir_pkg::REG_COS_Q14:      cos_ff    <= $signed(csr_write_data);
            nnir_pkg::REG_SIN_Q14:      sin_ff    <= $signed(csr_write_data);
            default: ;
         endcase
      end
   end

   // dimensions above the store size are clamped to it
   assign w_eff = (width_ff > nnir_pkg::DIM_W'(WCAP)) ? nnir_pkg::DIM_W'(WCAP) : width_ff;
   assign h_eff = (height_ff > nnir_pkg::DIM_W'(HCAP)) ? nnir_pkg::DIM_W'(HCAP) : height_ff;

   // ---------------- flow control ----------------
   assign s4_free = !s4_valid_ff || !rsp_stall;
   assign move3   = s3_valid_ff && s4_free;
   assign s3_free = !s3_valid_ff || move3;
   assign move2   = s2_valid_ff && s3_free;
   assign s2_free = !s2_valid_ff || move2;
   assign move1   = s1_valid_ff && s2_free;
   assign s1_free = !s1_valid_ff || move1;

   assign req_stall    = !s1_free;
   assign advance.prod = move1;
   assign advance.sum  = move2;

   assign s1_valid_in = s1_free ? req_valid : s1_valid_ff;
   assign s2_valid_in = s2_free ? move1 : s2_valid_ff;
   assign s3_valid_in = s3_free ? move2 : s3_valid_ff;
   // write transfers end at the store and give no response
   assign s4_valid_in = s4_free ? (move3 && s3_item_ff.action == nnir_pkg::ACTION_READ)
                                : s4_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free && req_valid) begin
         s1_item_ff.action   <= req_action;
         s1_item_ff.channel  <= req_channel;
         s1_item_ff.col      <= req_col;
         s1_item_ff.row      <= req_row;
         s1_item_ff.pixel_in <= req_pixel_in;
      end
      if (move1) begin
         s2_item_ff <= s1_item_ff;
      end
      if (move2) begin
         s3_item_ff <= s2_item_ff;
      end
   end

   // ---------------- coordinate mapping ----------------
   nnir_map u_map (
      .clock   (clock),
      .advance (advance),
      .col     (s1_item_ff.col),
      .row     (s1_item_ff.row),
      .width   (w_eff),
      .height  (h_eff),
      .cos_q14 (cos_ff),
      .sin_q14 (sin_ff),
      .nx      (nx),
      .ny      (ny)
   );

   // truncation toward zero: small negative sums land on zero
   assign x_below = nx[SW-1] && !((&nx[SW-1:FB]) && (|nx[FB-1:0]));
   assign y_below = ny[SW-1] && !((&ny[SW-1:FB]) && (|ny[FB-1:0]));
   assign sx      = nx[SW-1] ? '0 : nx[SW-1:FB];
   assign sy      = ny[SW-1] ? '0 : ny[SW-1:FB];
   assign x_off   = sx >= {{POS_PAD{1'b0}}, w_eff};
   assign y_off   = sy >= {{POS_PAD{1'b0}}, h_eff};
   assign ch_off  = 32'(s3_item_ff.channel) >= MAX_CHANNELS;

   assign outside_in = ch_off || x_below || y_below || x_off || y_off;

   assign rd_addr = AW'(s3_item_ff.channel) * AW'(PLANE_SIZE)
                  + AW'(sy) * AW'(MAX_WIDTH) + AW'(sx);
   assign wr_addr = AW'(s3_item_ff.channel) * AW'(PLANE_SIZE)
                  + AW'(s3_item_ff.row) * AW'(MAX_WIDTH) + AW'(s3_item_ff.col);
   assign wr_ok   = !ch_off
                  && 32'(s3_item_ff.col) < MAX_WIDTH
                  && 32'(s3_item_ff.row) < MAX_HEIGHT;

   // ---------------- image store ----------------
   always_ff @(posedge clock) begin
      if (move3 && s3_item_ff.action == nnir_pkg::ACTION_WRITE && wr_ok) begin
         image_mem[wr_addr] <= s3_item_ff.pixel_in;
      end
      if (move3 && s3_item_ff.action == nnir_pkg::ACTION_READ) begin
         rd_data_ff <= image_mem[rd_addr];
         outside_ff <= outside_in;
      end
   end

   assign rsp_valid     = s4_valid_ff;
   assign rsp_outside   = outside_ff;
   assign rsp_pixel_out = outside_ff ? '0 : rd_data_ff;

`ifndef SYNTHESIS
   // stall only when every stage holds an item
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff))
      else $error("request stalled with a free pipeline stage");

   // a write leaving the map stage never becomes a response
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (move3 && s3_item_ff.action == nnir_pkg::ACTION_WRITE) |=> !rsp_valid)
      else $error("write transfer produced a response");

   // a read leaving the map stage is presented next cycle
   a_read_shown: assert property (@(posedge clock) disable iff (reset)
      (move3 && s3_item_ff.action == nnir_pkg::ACTION_READ) |=> rsp_valid)
      else $error("read transfer lost");
`endif

endmodule

### tb/sv/tb_nearest_neighbor_image_rotate.sv
// ----------------------------------------------------------------------------
// tb_nearest_neighbor_image_rotate
// Self-checking bench for the image rotator: source pixels are written into
// the store, rotated pixels are read back under a range of image sizes and
// angles, and every result is compared with a bit-exact fixed-point mirror
// of the inverse mapping and the pixel store.
// ----------------------------------------------------------------------------
module tb_nearest_neighbor_image_rotate;

   localparam int MAX_W         = 128;
   localparam int MAX_H         = 128;
   localparam int MAX_CH        = 4;
   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [nnir_pkg::PIXEL_W-1:0] pixel;
      logic                         outside;
   } rotated_pixel_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_write_en = 1'b0;
   logic [nnir_pkg::CSR_IDX_W-1:0]   csr_index = '0;
   logic [nnir_pkg::TRIG_W-1:0]      csr_write_data = '0;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic                             req_action = nnir_pkg::ACTION_WRITE;
   logic [nnir_pkg::CHAN_W-1:0]      req_channel = '0;
   logic [nnir_pkg::COORD_W-1:0]     req_col = '0;
   logic [nnir_pkg::COORD_W-1:0]     req_row = '0;
   logic [nnir_pkg::PIXEL_W-1:0]     req_pixel_in = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [nnir_pkg::PIXEL_W-1:0]     rsp_pixel_out;
   logic                             rsp_outside;

   // rotation settings as the block should hold them
   logic [nnir_pkg::DIM_W-1:0]         rot_width  = nnir_pkg::RESET_WIDTH;
   logic [nnir_pkg::DIM_W-1:0]         rot_height = nnir_pkg::RESET_HEIGHT;
   logic signed [nnir_pkg::TRIG_W-1:0] rot_cos    = nnir_pkg::RESET_COS;
   logic signed [nnir_pkg::TRIG_W-1:0] rot_sin    = nnir_pkg::RESET_SIN;

   logic [nnir_pkg::PIXEL_W-1:0] pixel_mirror   [0:MAX_CH*MAX_H*MAX_W-1];
   bit                           pixel_written  [0:MAX_CH*MAX_H*MAX_W-1];

   nnir_pkg::item_type pending_items[$];
   rotated_pixel_type  expected_pixels[$];

   int                 mismatch_count = 0;
   int                 idle_cycles = 0;
   int                 burst_left = 0;
   int                 gap_left = 0;
   int                 stall_left = 0;
   int                 stall_mode = 0;
   logic               req_accepted = 1'b0;
   nnir_pkg::item_type next_req;

   nearest_neighbor_image_rotate #(
      .MAX_WIDTH   (MAX_W),
      .MAX_HEIGHT  (MAX_H),
      .MAX_CHANNELS(MAX_CH)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_write_data(csr_write_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_channel   (req_channel),
      .req_col       (req_col),
      .req_row       (req_row),
      .req_pixel_in  (req_pixel_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_outside   (rsp_outside)
   );

   always #5 clock = ~clock;

   // inverse rotation in units of 2^-15, truncated toward zero
   function automatic logic map_source(input logic [nnir_pkg::CHAN_W-1:0] ch,
                                       input logic [nnir_pkg::COORD_W-1:0] x,
                                       input logic [nnir_pkg::COORD_W-1:0] y,
                                       output logic [15:0] addr);
      longint w, h, dx2, dy2, nx, ny, sx, sy;
      w   = (rot_width > MAX_W) ? MAX_W : rot_width;
      h   = (rot_height > MAX_H) ? MAX_H : rot_height;
      dx2 = 2 * longint'(x) - w;
      dy2 = 2 * longint'(y) - h;
      nx  = w * 16384 + dx2 * longint'(rot_cos) + dy2 * longint'(rot_sin) + 16384;
      ny  = h * 16384 - dx2 * longint'(rot_sin) + dy2 * longint'(rot_cos) + 16384;
      sx  = nx / 32768;
      sy  = ny / 32768;
      addr = {ch, sy[nnir_pkg::COORD_W-1:0], sx[nnir_pkg::COORD_W-1:0]};
      return (sx >= 0 && sy >= 0 && sx < w && sy < h);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic queue_write(input logic [nnir_pkg::CHAN_W-1:0] ch,
                              input logic [nnir_pkg::COORD_W-1:0] x,
                              input logic [nnir_pkg::COORD_W-1:0] y,
                              input logic [nnir_pkg::PIXEL_W-1:0] pix);
      nnir_pkg::item_type it;
      it.action   = nnir_pkg::ACTION_WRITE;
      it.channel  = ch;
      it.col      = x;
      it.row      = y;
      it.pixel_in = pix;
      pending_items.push_back(it);
      pixel_written[{ch, y, x}] = 1'b1;
   endtask

   // a read whose source pixel was never stored gets that pixel written first
   task automatic queue_read(input logic [nnir_pkg::CHAN_W-1:0] ch,
                             input logic [nnir_pkg::COORD_W-1:0] x,
                             input logic [nnir_pkg::COORD_W-1:0] y);
      nnir_pkg::item_type it;
      logic [15:0]        addr;
      if (map_source(ch, x, y, addr) && !pixel_written[addr])
         queue_write(addr[15:14], addr[6:0], addr[13:7], 8'($urandom));
      it.action   = nnir_pkg::ACTION_READ;
      it.channel  = ch;
      it.col      = x;
      it.row      = y;
      it.pixel_in = 8'($urandom);
      pending_items.push_back(it);
   endtask

   task automatic random_traffic(input int count);
      int ew, eh;
      logic [nnir_pkg::COORD_W-1:0] x, y;
      ew = (rot_width > MAX_W) ? MAX_W : rot_width;
      eh = (rot_height > MAX_H) ? MAX_H : rot_height;
      repeat (count) begin
         // mostly inside the image in use, now and then anywhere
         if (ew > 0 && eh > 0 && $urandom_range(0, 9) < 8) begin
            x = 7'($urandom_range(0, ew - 1));
            y = 7'($urandom_range(0, eh - 1));
         end else begin
            x = 7'($urandom);
            y = 7'($urandom);
         end
         if ($urandom_range(0, 9) < 6)
            queue_read(2'($urandom), x, y);
         else
            queue_write(2'($urandom), x, y, 8'($urandom));
      end
   endtask

   // wait for an unbroken quiet stretch: writes give no result and need time to drain
   task automatic wait_idle();
      int quiet;
      quiet = 0;
      while (quiet < SETTLE_CYCLES) begin
         @(negedge clock);
         if (pending_items.size() != 0 || req_valid || expected_pixels.size() != 0)
            quiet = 0;
         else
            quiet++;
      end
   endtask

   task automatic csr_write(input logic [nnir_pkg::CSR_IDX_W-1:0] idx,
                            input logic [nnir_pkg::TRIG_W-1:0] data);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      case (idx)
         nnir_pkg::REG_IMAGE_WIDTH:  rot_width  = data[nnir_pkg::DIM_W-1:0];
         nnir_pkg::REG_IMAGE_HEIGHT: rot_height = data[nnir_pkg::DIM_W-1:0];
         nnir_pkg::REG_COS_Q14:      rot_cos    = data;
         nnir_pkg::REG_SIN_Q14:      rot_sin    = data;
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic run_phase(input logic [nnir_pkg::DIM_W-1:0] w,
                            input logic [nnir_pkg::DIM_W-1:0] h,
                            input logic signed [nnir_pkg::TRIG_W-1:0] c,
                            input logic signed [nnir_pkg::TRIG_W-1:0] s, input int count);
      wait_idle();
      // upper byte of the dimension writes is junk the block must drop
      csr_write(nnir_pkg::REG_IMAGE_WIDTH, {8'($urandom), w});
      csr_write(nnir_pkg::REG_IMAGE_HEIGHT, {8'($urandom), h});
      csr_write(nnir_pkg::REG_COS_Q14, c);
      csr_write(nnir_pkg::REG_SIN_Q14, s);
      queue_read(2'($urandom), 7'd0, 7'd0);
      queue_read(2'($urandom), 7'd127, 7'd127);
      random_traffic(count);
   endtask

   function automatic logic [nnir_pkg::DIM_W-1:0] pick_dim();
      case ($urandom_range(0, 9))
         0:       return 8'($urandom);
         1:       return 8'($urandom_range(1, MAX_W));
         default: return 8'($urandom_range(1, 24));
      endcase
   endfunction

   // request driver: bursts of transfers with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (gap_left != 0 || pending_items.size() == 0) begin
            if (gap_left != 0)
               gap_left--;
            req_valid <= 1'b0;
         end else begin
            next_req = pending_items.pop_front();
            req_valid    <= 1'b1;
            req_action   <= next_req.action;
            req_channel  <= next_req.channel;
            req_col      <= next_req.col;
            req_row      <= next_req.row;
            req_pixel_in <= next_req.pixel_in;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end
      end
   end

   // result stall pattern: free, light, heavy or alternating stretches
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 96);
         end
         stall_left--;
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= stall_left[0];
         endcase
      end
   end

   // monitor: check results, then update the mirror with the accepted request
   always @(posedge clock) begin
      rotated_pixel_type want;
      logic [15:0]       addr;
      logic              src_inside;
      if (reset) begin
         req_accepted <= 1'b0;
      end else begin
         req_accepted <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("unexpected result pixel %0d outside %0b",
                                         rsp_pixel_out, rsp_outside));
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pixel_out !== want.pixel)
                  report_mismatch($sformatf("pixel_out %0d, wanted %0d",
                                            rsp_pixel_out, want.pixel));
               if (rsp_outside !== want.outside)
                  report_mismatch($sformatf("outside %0b, wanted %0b",
                                            rsp_outside, want.outside));
            end
         end
         if (req_valid && !req_stall) begin
            if (req_action == nnir_pkg::ACTION_WRITE) begin
               pixel_mirror[{req_channel, req_row, req_col}] = req_pixel_in;
            end else begin
               src_inside   = map_source(req_channel, req_col, req_row, addr);
               want.pixel   = src_inside ? pixel_mirror[addr] : '0;
               want.outside = !src_inside;
               expected_pixels.push_back(want);
            end
         end
      end
   end

   // watchdog: too long with work outstanding and no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (pending_items.size() == 0 && !req_valid && expected_pixels.size() == 0)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      real                                angle;
      logic signed [nnir_pkg::TRIG_W-1:0] c, s;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // reset settings give the identity mapping; bit patterns at the extremes
      queue_write(2'd0, 7'd0, 7'd0, 8'h00);
      queue_write(2'd3, 7'd127, 7'd127, 8'hFF);
      queue_write(2'd1, 7'd85, 7'd42, 8'hAA);
      queue_write(2'd2, 7'd42, 7'd85, 8'h55);
      queue_read(2'd0, 7'd0, 7'd0);
      queue_read(2'd3, 7'd127, 7'd127);
      queue_read(2'd1, 7'd85, 7'd42);
      queue_read(2'd2, 7'd42, 7'd85);
      random_traffic(30);

      run_phase(8'd128, 8'd128, 16'sd0, 16'sd16384, 30);        // quarter turn
      run_phase(8'd128, 8'd128, -16'sd16384, 16'sd0, 30);       // half turn
      run_phase(8'd0, 8'd9, 16'sd16384, 16'sd0, 20);            // zero width
      run_phase(8'd7, 8'd0, 16'sd11585, 16'sd11585, 20);        // zero height
      run_phase(8'd255, 8'd200, 16'sd16384, 16'sd0, 30);        // oversized, clamped
      run_phase(8'd1, 8'd1, 16'sd16384, 16'sd0, 30);
      run_phase(8'd5, 8'd3, 16'sd0, -16'sd16384, 30);
      run_phase(8'd16, 8'd16, -16'sd32768, 16'sd32767, 30);     // trig register extremes
      run_phase(8'd16, 8'd16, 16'sd32767, -16'sd32768, 30);
      run_phase(8'd128, 8'd128, 16'sd11585, -16'sd11585, 30);

      repeat (8) begin
         if ($urandom_range(0, 9) < 7) begin
            angle = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
            c = 16'($rtoi($cos(angle) * 16384.0));
            s = 16'($rtoi($sin(angle) * 16384.0));
         end else begin
            c = 16'($urandom);
            s = 16'($urandom);
         end
         run_phase(pick_dim(), pick_dim(), c, s, 30);
      end

      wait_idle();
      repeat (16) @(negedge clock);
      if (expected_pixels.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_pixels.size()));
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
